// ----- rtl/core/cna_pkg.sv -----
package cna_pkg;

  localparam int FIELD_W        = 32;
  localparam int OP_W           = 3;
  localparam int TOL_W          = 16;
  localparam int MAG_W          = 64;
  localparam int QUO_W          = 41;
  localparam int WIDE_W         = 66;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_NEG  = 3'd5,
    OP_CMP  = 3'd6
  } cna_op_e;

  // side-band that rides alongside the divider
  typedef struct packed {
    logic               is_div;
    logic               div_zero;
    logic               neg_re;
    logic               neg_im;
    logic [FIELD_W-1:0] res_re;
    logic [FIELD_W-1:0] res_im;
    logic               is_equal;
    logic               saturated;
  } cna_side_t;

  typedef struct packed {
    logic [MAG_W-1:0] num_re;
    logic [MAG_W-1:0] num_im;
    logic [MAG_W-1:0] den;
    logic [MAG_W-1:0] rem_re;
    logic [MAG_W-1:0] rem_im;
    logic [QUO_W-1:0] quo_re;
    logic [QUO_W-1:0] quo_im;
    logic             stk_re;
    logic             stk_im;
  } cna_div_t;

  typedef struct packed {
    logic [FIELD_W-1:0] val;
    logic               clip;
  } cna_sat_t;

  function automatic cna_sat_t cna_sat(input logic signed [WIDE_W-1:0] v,
                                       input logic signed [WIDE_W-1:0] maxv,
                                       input logic signed [WIDE_W-1:0] minv);
    cna_sat_t s;
    if (v > maxv) begin
      s.val  = maxv[FIELD_W-1:0];
      s.clip = 1'b1;
    end else if (v < minv) begin
      s.val  = minv[FIELD_W-1:0];
      s.clip = 1'b1;
    end else begin
      s.val  = v[FIELD_W-1:0];
      s.clip = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/cna_front.sv -----
module cna_front #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [cna_pkg::OP_W-1:0]    op_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_im_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_im_i,
  input  logic [cna_pkg::TOL_W-1:0]   tol_i,
  output logic                        valid_o,
  output cna_pkg::cna_side_t          side_o,
  output cna_pkg::cna_div_t           div_o
);

  localparam int WEFF = (DATA_WIDTH > cna_pkg::FIELD_W) ? cna_pkg::FIELD_W : DATA_WIDTH;
  localparam int W    = cna_pkg::WIDE_W;
  localparam logic signed [W-1:0] MAXV = (W'(1) <<< (WEFF - 1)) - W'(1);
  localparam logic signed [W-1:0] MINV = -(W'(1) <<< (WEFF - 1));

  logic signed [31:0] ar, ai, br, bi;

  // stage 1: products and linear terms
  logic               v1_q;
  logic [cna_pkg::OP_W-1:0]  op1_q;
  logic [cna_pkg::TOL_W-1:0] tol1_q;
  logic signed [63:0] prr_q, pii_q, pri_q, pir_q, sqr_q, sqi_q;
  logic signed [33:0] lin_re_d, lin_im_d, lin_re_q, lin_im_q;

  assign ar = 32'(signed'(a_re_i[WEFF-1:0]));
  assign ai = 32'(signed'(a_im_i[WEFF-1:0]));
  assign br = 32'(signed'(b_re_i[WEFF-1:0]));
  assign bi = 32'(signed'(b_im_i[WEFF-1:0]));

  always_comb begin
    lin_re_d = '0;
    lin_im_d = '0;
    unique case (cna_pkg::cna_op_e'(op_i)) inside
      cna_pkg::OP_ADD: begin
        lin_re_d = 34'(ar) + 34'(br);
        lin_im_d = 34'(ai) + 34'(bi);
      end
      cna_pkg::OP_SUB, cna_pkg::OP_CMP: begin
        lin_re_d = 34'(ar) - 34'(br);
        lin_im_d = 34'(ai) - 34'(bi);
      end
      cna_pkg::OP_CONJ: begin
        lin_re_d = 34'(ar);
        lin_im_d = -34'(ai);
      end
      cna_pkg::OP_NEG: begin
        lin_re_d = -34'(ar);
        lin_im_d = -34'(ai);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q    <= op_i;
    tol1_q   <= tol_i;
    prr_q    <= 64'(ar) * 64'(br);
    pii_q    <= 64'(ai) * 64'(bi);
    pri_q    <= 64'(ar) * 64'(bi);
    pir_q    <= 64'(ai) * 64'(br);
    sqr_q    <= 64'(br) * 64'(br);
    sqi_q    <= 64'(bi) * 64'(bi);
    lin_re_q <= lin_re_d;
    lin_im_q <= lin_im_d;
  end

  // stage 2: sums, magnitudes, results of everything but divide
  logic signed [W-1:0] t_re, t_im, vm_re, vm_im;
  logic                neg_re, neg_im;
  logic [63:0]         mag_re, mag_im, den;
  logic [33:0]         abs_re, abs_im;
  cna_pkg::cna_sat_t   s_re, s_im;
  cna_pkg::cna_side_t  side_d;
  cna_pkg::cna_div_t   div_d;
  logic                is_mul;

  always_comb begin
    is_mul = (cna_pkg::cna_op_e'(op1_q) == cna_pkg::OP_MUL);
    if (is_mul) begin
      t_re = W'(prr_q) - W'(pii_q);
      t_im = W'(pri_q) + W'(pir_q);
    end else begin
      t_re = W'(prr_q) + W'(pii_q);
      t_im = W'(pir_q) - W'(pri_q);
    end
    neg_re = t_re[W-1];
    neg_im = t_im[W-1];
    mag_re = neg_re ? 64'(-t_re) : 64'(t_re);
    mag_im = neg_im ? 64'(-t_im) : 64'(t_im);
    vm_re  = signed'({2'b00, mag_re >> FRAC_BITS});
    vm_im  = signed'({2'b00, mag_im >> FRAC_BITS});
    den    = 64'(sqr_q) + 64'(sqi_q);
    abs_re = lin_re_q[33] ? 34'(-lin_re_q) : 34'(lin_re_q);
    abs_im = lin_im_q[33] ? 34'(-lin_im_q) : 34'(lin_im_q);

    if (is_mul) begin
      s_re = cna_pkg::cna_sat(neg_re ? -vm_re : vm_re, MAXV, MINV);
      s_im = cna_pkg::cna_sat(neg_im ? -vm_im : vm_im, MAXV, MINV);
    end else begin
      s_re = cna_pkg::cna_sat(W'(lin_re_q), MAXV, MINV);
      s_im = cna_pkg::cna_sat(W'(lin_im_q), MAXV, MINV);
    end

    side_d           = '0;
    side_d.neg_re    = neg_re;
    side_d.neg_im    = neg_im;
    unique case (cna_pkg::cna_op_e'(op1_q)) inside
      cna_pkg::OP_ADD, cna_pkg::OP_SUB, cna_pkg::OP_MUL,
      cna_pkg::OP_CONJ, cna_pkg::OP_NEG: begin
        side_d.res_re    = s_re.val;
        side_d.res_im    = s_im.val;
        side_d.saturated = s_re.clip | s_im.clip;
      end
      cna_pkg::OP_DIV: begin
        side_d.div_zero = (den == '0);
        side_d.is_div   = (den != '0);
      end
      cna_pkg::OP_CMP: begin
        side_d.is_equal = (abs_re <= 34'(tol1_q)) && (abs_im <= 34'(tol1_q));
      end
      default: ;
    endcase

    div_d        = '0;
    div_d.num_re = mag_re;
    div_d.num_im = mag_im;
    div_d.den    = den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_d;
    div_o  <= div_d;
  end

endmodule

// ----- rtl/core/cna_div_stage.sv -----
module cna_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cna_pkg::cna_side_t side_i,
  input  cna_pkg::cna_div_t  div_i,
  output logic               valid_o,
  output cna_pkg::cna_side_t side_o,
  output cna_pkg::cna_div_t  div_o
);

  localparam int M = cna_pkg::MAG_W;
  localparam int Q = cna_pkg::QUO_W;

  logic [M:0]        sh_re, sh_im, den_x, df_re, df_im;
  logic              ge_re, ge_im;
  cna_pkg::cna_div_t div_d;

  // one restoring step per lane; dividend bits come off the top of num
  always_comb begin
    den_x  = {1'b0, div_i.den};
    sh_re  = {div_i.rem_re, div_i.num_re[M-1]};
    sh_im  = {div_i.rem_im, div_i.num_im[M-1]};
    ge_re  = (sh_re >= den_x);
    ge_im  = (sh_im >= den_x);
    df_re  = sh_re - den_x;
    df_im  = sh_im - den_x;

    div_d        = div_i;
    div_d.num_re = div_i.num_re << 1;
    div_d.num_im = div_i.num_im << 1;
    div_d.rem_re = ge_re ? df_re[M-1:0] : sh_re[M-1:0];
    div_d.rem_im = ge_im ? df_im[M-1:0] : sh_im[M-1:0];
    div_d.quo_re = {div_i.quo_re[Q-2:0], ge_re};
    div_d.quo_im = {div_i.quo_im[Q-2:0], ge_im};
    div_d.stk_re = div_i.stk_re | div_i.quo_re[Q-1];
    div_d.stk_im = div_i.stk_im | div_i.quo_im[Q-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    div_o  <= div_d;
  end

endmodule

// ----- rtl/core/complex_number_alu.sv -----
// Complex arithmetic unit on signed fixed-point operands (Q16.16 by default).
// Input: drive op_i and the four operand parts with start_i high; a word is
// taken at every clock edge where start_i is high and busy_o low. busy_o is
// never raised, so a new word may enter every cycle.
// Output: each word yields one result, shown for a single cycle with done_o
// high. Every op takes the same path: the input register, two product/sum
// stages, 64 + FRAC_BITS divider stages with one restoring step per pipeline
// stage, and the output register, in that order.
// Throughput is one word per cycle.
// eq_tolerance_i is written when eq_tolerance_we_i is high; change it only
// when nothing is in flight.
// Reset clears every valid bit in the pipe and the tolerance; words in
// flight are dropped. The receiver cannot stall, so done_o is never held.
module complex_number_alu #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [cna_pkg::OP_W-1:0]    op_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_im_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_im_i,
  input  logic                        eq_tolerance_we_i,
  input  logic [cna_pkg::TOL_W-1:0]   eq_tolerance_i,
  output logic                        done_o,
  output logic [cna_pkg::FIELD_W-1:0] res_re_o,
  output logic [cna_pkg::FIELD_W-1:0] res_im_o,
  output logic                        is_equal_o,
  output logic                        div_zero_o,
  output logic                        saturated_o
);

  localparam int NSTEP   = cna_pkg::MAG_W + FRAC_BITS;
  localparam int LATENCY = NSTEP + 4;
  localparam int WEFF    = (DATA_WIDTH > cna_pkg::FIELD_W) ? cna_pkg::FIELD_W : DATA_WIDTH;
  localparam int W       = cna_pkg::WIDE_W;
  localparam int Q       = cna_pkg::QUO_W;
  localparam logic signed [W-1:0] MAXV = (W'(1) <<< (WEFF - 1)) - W'(1);
  localparam logic signed [W-1:0] MINV = -(W'(1) <<< (WEFF - 1));

  logic [cna_pkg::TOL_W-1:0]   tol_q;
  logic                        in_v_q;
  logic [cna_pkg::OP_W-1:0]    op_q;
  logic [cna_pkg::FIELD_W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= '0;
      in_v_q <= 1'b0;
    end else begin
      if (eq_tolerance_we_i) begin
        tol_q <= eq_tolerance_i;
      end
      in_v_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_i;
    a_re_q <= a_re_i;
    a_im_q <= a_im_i;
    b_re_q <= b_re_i;
    b_im_q <= b_im_i;
  end

  logic               v_pipe    [NSTEP+1];
  cna_pkg::cna_side_t side_pipe [NSTEP+1];
  cna_pkg::cna_div_t  div_pipe  [NSTEP+1];

  cna_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .op_i    (op_q),
    .a_re_i  (a_re_q),
    .a_im_i  (a_im_q),
    .b_re_i  (b_re_q),
    .b_im_i  (b_im_q),
    .tol_i   (tol_q),
    .valid_o (v_pipe[0]),
    .side_o  (side_pipe[0]),
    .div_o   (div_pipe[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_div
    cna_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_pipe[g]),
      .side_i  (side_pipe[g]),
      .div_i   (div_pipe[g]),
      .valid_o (v_pipe[g+1]),
      .side_o  (side_pipe[g+1]),
      .div_o   (div_pipe[g+1])
    );
  end

  // quotient at or above 2^40 always clips, so the sticky bit stands in for it
  cna_pkg::cna_side_t  fin;
  cna_pkg::cna_div_t   dv;
  logic [Q-1:0]        qr, qi;
  logic signed [W-1:0] vr, vi;
  cna_pkg::cna_sat_t   sr, si;

  always_comb begin
    fin = side_pipe[NSTEP];
    dv  = div_pipe[NSTEP];
    qr  = dv.stk_re ? (Q'(1) << (Q - 1)) : dv.quo_re;
    qi  = dv.stk_im ? (Q'(1) << (Q - 1)) : dv.quo_im;
    vr  = signed'(W'(qr));
    vi  = signed'(W'(qi));
    sr  = cna_pkg::cna_sat(fin.neg_re ? -vr : vr, MAXV, MINV);
    si  = cna_pkg::cna_sat(fin.neg_im ? -vi : vi, MAXV, MINV);
    if (fin.is_div) begin
      fin.res_re    = sr.val;
      fin.res_im    = si.val;
      fin.saturated = sr.clip | si.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= v_pipe[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_o    <= fin.res_re;
    res_im_o    <= fin.res_im;
    is_equal_o  <= fin.is_equal;
    div_zero_o  <= fin.div_zero;
    saturated_o <= fin.saturated;
  end

endmodule

// ----- rtl/core/cna_checker.sv -----
module cna_checker #(
  parameter int LAT = 84
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [cna_pkg::FIELD_W-1:0] res_re_o,
  input logic [cna_pkg::FIELD_W-1:0] res_im_o,
  input logic                        is_equal_o,
  input logic                        div_zero_o,
  input logic                        saturated_o
);

  // every accepted word comes out a fixed time later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("word not delivered at fixed latency");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 && !saturated_o)
    else $error("divide by zero result not cleared");

  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_equal_o |-> res_re_o == '0 && res_im_o == '0 && !saturated_o)
    else $error("compare result not cleared");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_equal_o && div_zero_o))
    else $error("compare and divide flags together");

endmodule

bind complex_number_alu cna_checker #(.LAT(LATENCY)) u_cna_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .res_re_o    (res_re_o),
  .res_im_o    (res_im_o),
  .is_equal_o  (is_equal_o),
  .div_zero_o  (div_zero_o),
  .saturated_o (saturated_o)
);

// ----- sim/complex_number_alu_checker.sv -----
`timescale 1ns / 100ps

module complex_number_alu_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [cna_pkg::OP_W-1:0]    op_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] a_im_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] b_im_i,
  input  logic                        tol_we_i,
  input  logic [cna_pkg::TOL_W-1:0]   tol_i,
  input  logic                        done_i,
  input  logic [cna_pkg::FIELD_W-1:0] res_re_i,
  input  logic [cna_pkg::FIELD_W-1:0] res_im_i,
  input  logic                        is_equal_i,
  input  logic                        div_zero_i,
  input  logic                        saturated_i,
  output int                          errors_o,
  output int                          pending_o
);

  localparam int FRAC = cna_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] MIN_MAG = 64'h8000_0000;
  localparam logic [63:0] MAX_MAG = 64'h7FFF_FFFF;
  localparam logic [63:0] QUO_CAP = 64'd1 << 40;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic        dz;
    logic        sat;
  } cplx_word_t;

  cplx_word_t   expected_q[$];
  logic [15:0]  tolerance;

  assign pending_o = expected_q.size();

  function automatic logic [31:0] clip_mag(input logic neg, input logic [63:0] mag,
                                           inout logic f);
    if (neg) begin
      if (mag > MIN_MAG) begin
        f = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > MAX_MAG) begin
      f = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] clip_val(input logic signed [63:0] v, inout logic f);
    return clip_mag(v < 0, v < 0 ? 64'(-v) : 64'(v), f);
  endfunction

  // exact sum of two 64-bit products; a wrap to 2^63 is positive
  function automatic void sum_split(input logic signed [63:0] x, input logic signed [63:0] y,
                                    output logic neg, output logic [63:0] mag);
    logic [63:0] s;
    s = x + y;
    if (s == 64'h8000_0000_0000_0000) begin
      neg = 1'b0;
      mag = s;
    end else if (s[63]) begin
      neg = 1'b1;
      mag = -s;
    end else begin
      neg = 1'b0;
      mag = s;
    end
  endfunction

  function automatic logic [63:0] frac_quot(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 0; i < 64 + FRAC; i++) begin
      r = {r[63:0], (i < 64) ? num[63-i] : 1'b0};
      q = (q >= QUO_CAP) ? QUO_CAP : (q << 1);
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        if (q < QUO_CAP) q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic cplx_word_t alu_result(input logic [2:0] op, input logic [31:0] ar_u,
                                            input logic [31:0] ai_u, input logic [31:0] br_u,
                                            input logic [31:0] bi_u, input logic [15:0] tol);
    cplx_word_t w;
    logic signed [63:0] ar, ai, br, bi, dr, di;
    logic [63:0] den, mag;
    logic neg, f;
    ar = 64'(signed'(ar_u));
    ai = 64'(signed'(ai_u));
    br = 64'(signed'(br_u));
    bi = 64'(signed'(bi_u));
    w = '0;
    f = 1'b0;
    case (op)
      cna_pkg::OP_ADD: begin
        w.re = clip_val(ar + br, f);
        w.im = clip_val(ai + bi, f);
      end
      cna_pkg::OP_SUB: begin
        w.re = clip_val(ar - br, f);
        w.im = clip_val(ai - bi, f);
      end
      cna_pkg::OP_MUL: begin
        sum_split(ar * br, -(ai * bi), neg, mag);
        w.re = clip_mag(neg, mag >> FRAC, f);
        sum_split(ar * bi, ai * br, neg, mag);
        w.im = clip_mag(neg, mag >> FRAC, f);
      end
      cna_pkg::OP_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) begin
          w.dz = 1'b1;
        end else begin
          sum_split(ar * br, ai * bi, neg, mag);
          w.re = clip_mag(neg, frac_quot(mag, den), f);
          sum_split(ai * br, -(ar * bi), neg, mag);
          w.im = clip_mag(neg, frac_quot(mag, den), f);
        end
      end
      cna_pkg::OP_CONJ: begin
        w.re = ar_u;
        w.im = clip_val(-ai, f);
      end
      cna_pkg::OP_NEG: begin
        w.re = clip_val(-ar, f);
        w.im = clip_val(-ai, f);
      end
      cna_pkg::OP_CMP: begin
        dr = ar - br;
        di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        w.eq = (dr <= tol) && (di <= tol);
      end
      default: ;
    endcase
    w.sat = f;
    return w;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    cplx_word_t exp_w;
    if (!rst_ni) begin
      tolerance <= '0;
      errors_o  <= 0;
      expected_q.delete();
    end else begin
      if (tol_we_i) tolerance <= tol_i;
      if (start_i && !busy_i)
        expected_q.push_back(alu_result(op_i, a_re_i, a_im_i, b_re_i, b_im_i, tolerance));
      if (done_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word at %0t", $realtime);
          errors_o <= errors_o + 1;
        end else begin
          exp_w = expected_q.pop_front();
          if (exp_w != {res_re_i, res_im_i, is_equal_i, div_zero_i, saturated_i}) begin
            if (errors_o < 10)
              $display({"mismatch: exp re=%h im=%h eq=%b dz=%b sat=%b ",
                        "got re=%h im=%h eq=%b dz=%b sat=%b"},
                       exp_w.re, exp_w.im, exp_w.eq, exp_w.dz, exp_w.sat,
                       res_re_i, res_im_i, is_equal_i, div_zero_i, saturated_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/complex_number_alu_tb.sv -----
`timescale 1ns / 100ps

module complex_number_alu_tb;

  localparam int LATENCY   = cna_pkg::FRAC_BITS_DEF + 68;
  localparam int IDLE_CAP  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  op_i = '0;
  logic [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic        tol_we_i = 1'b0;
  logic [15:0] tol_i = '0;
  logic        done_o, is_equal_o, div_zero_o, saturated_o;
  logic [31:0] res_re_o, res_im_o;
  int          errors, pending, quiet_cycles;
  int          idle_pct;

  always #1 clk_i = ~clk_i;

  complex_number_alu dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .eq_tolerance_we_i(tol_we_i), .eq_tolerance_i(tol_i), .done_o, .res_re_o,
    .res_im_o, .is_equal_o, .div_zero_o, .saturated_o
  );

  complex_number_alu_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .a_re_i, .a_im_i, .b_re_i,
    .b_im_i, .tol_we_i, .tol_i, .done_i(done_o), .res_re_i(res_re_o),
    .res_im_i(res_im_o), .is_equal_i(is_equal_o), .div_zero_i(div_zero_o),
    .saturated_i(saturated_o), .errors_o(errors), .pending_o(pending)
  );

  // watchdog: cycles in which no word moves either way
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      4, 5: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    a_re_i  <= ar;
    a_im_i  <= ai;
    b_re_i  <= br;
    b_im_i  <= bi;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [15:0] v);
    drain_pipe();
    tol_we_i <= 1'b1;
    tol_i    <= v;
    @(posedge clk_i);
    tol_we_i <= 1'b0;
  endtask

  task automatic random_word();
    logic [2:0]  op;
    logic [31:0] ar, ai, br, bi;
    op = 3'($urandom_range(0, 7));
    ar = pick_part();
    ai = pick_part();
    br = pick_part();
    bi = pick_part();
    if (op == cna_pkg::OP_CMP && $urandom_range(0, 1)) begin
      br = ar + 32'($signed($urandom_range(0, 4)) - 2);
      bi = ai + 32'($signed($urandom_range(0, 131072)) - 65536);
    end
    if (op == cna_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
      br = '0;
      bi = '0;
    end
    send_word(op, ar, ai, br, bi);
  endtask

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every op, zero divisor, negating the minimum, spare op code
    send_word(cna_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cna_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_word(cna_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cna_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
    send_word(cna_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(cna_pkg::OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(cna_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0003, 32'h0000_0000);
    send_word(cna_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cna_pkg::OP_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    send_word(cna_pkg::OP_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000);
    send_word(cna_pkg::OP_CONJ, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_word(cna_pkg::OP_CONJ, 32'h1234_5678, 32'h7FFF_FFFF, '1, '1);
    send_word(cna_pkg::OP_NEG, 32'h8000_0000, 32'h0000_0001, '0, '0);
    send_word(cna_pkg::OP_NEG, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    send_word(cna_pkg::OP_CMP, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005);
    send_word(cna_pkg::OP_CMP, 32'h0000_0005, 32'h0000_0005, 32'h0000_0006, 32'h0000_0005);
    send_word(cna_pkg::OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(3'd7, '1, '1, '1, '1);

    set_tolerance(16'hFFFF);
    send_word(cna_pkg::OP_CMP, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0001);
    send_word(cna_pkg::OP_CMP, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
    send_word(cna_pkg::OP_CMP, 32'h8000_0000, 32'h8000_0000, 32'h8000_FFFF, 32'h7FFF_0001);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      case (ph)
        0: set_tolerance(16'h0000);
        1: set_tolerance(16'h0001);
        7: set_tolerance(16'hFFFF);
        default: set_tolerance(16'($urandom()));
      endcase
      repeat (150) random_word();
    end

    drain_pipe();
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cna_pkg.sv
rtl/core/cna_front.sv
rtl/core/cna_div_stage.sv
rtl/core/complex_number_alu.sv
rtl/core/cna_checker.sv
sim/complex_number_alu_checker.sv
sim/complex_number_alu_tb.sv
